// ===== rtl/dtf_pkg.sv =====
package dtf_pkg;

    localparam int unsigned DecWidth    = 5;
    localparam int unsigned ValueWidth  = 64;
    localparam logic [DecWidth-1:0] MaxDecimals   = 5'd19;
    localparam logic [DecWidth-1:0] ResetDecimals = 5'd18;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StEmpty = 2'd1;
    localparam logic [1:0] StBad   = 2'd2;
    localparam logic [1:0] StOvf   = 2'd3;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChDot   = 8'h2e;
    localparam logic [7:0] ChSpace = 8'h20;

    typedef struct packed {
        logic       has_char;
        logic [7:0] character;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [1:0]            status;
    } out_t;

    typedef struct packed {
        logic take;
        logic scale_step;
        logic finish;
    } dtf_cmd_t;

    typedef struct packed {
        logic scale_done;
    } dtf_stat_t;

endpackage

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Decimal text to fixed-point integer.
// Input channel (in_valid/in_ready/in_data): one ASCII character per request,
// has_char = 0 carries no byte, last marks the final request of a string.
// Output channel (out_valid/out_ready/out_data): one result per string,
// value = whole * 10^decimals + fraction, status ok/empty/bad/overflow.
// cfg_write_en/cfg_write_data write the decimals register (reset 18,
// values above 19 act as 19); write only while the block is idle.
// Throughput: one character per cycle within a string. After the last
// character the scaling unit multiplies by ten once per cycle until it has
// done decimals steps, detects completion, then does the final add, which
// waits until the output register is free. in_ready is low from the last
// character until the result is loaded.
// Results sit in an output register; while it waits for out_ready the next
// string's characters are still taken, and back-pressure stalls the block only when a
// new result is ready and the previous one has not yet been taken.
// Reset clears parse state and output valid, and sets decimals to 18.
module decimal_text_to_fixed_point (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dtf_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dtf_pkg::out_t                 out_data,
    input  logic                          cfg_write_en,
    input  logic [dtf_pkg::DecWidth-1:0]  cfg_write_data
);

    dtf_pkg::dtf_cmd_t  cmd;
    dtf_pkg::dtf_stat_t stat;

    dtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_char  (in_data.has_char),
        .last      (in_data.last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dtf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_data        (in_data),
        .cmd            (cmd),
        .stat           (stat),
        .out_data       (out_data)
    );

endmodule

// ===== rtl/dtf_ctrl.sv =====
module dtf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               has_char,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output dtf_pkg::dtf_cmd_t  cmd,
    input  dtf_pkg::dtf_stat_t stat
);

    typedef enum logic [1:0] {
        S_IN,
        S_SCALE,
        S_SUM
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IN);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd.take       = accept && has_char;
        cmd.scale_step = (state_reg == S_SCALE) && !stat.scale_done;
        cmd.finish     = (state_reg == S_SUM) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IN:
            begin
                if (accept && last)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (stat.scale_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (cmd.finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IN;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result load never overwrites an untaken result
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("finish while output occupied");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finish did not raise out_valid");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input taken during scaling");

    a_no_overstep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale_step |-> !stat.scale_done)
        else $error("scale step past decimals");

endmodule

// ===== rtl/dtf_dp.sv =====
module dtf_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [dtf_pkg::DecWidth-1:0]     cfg_write_data,
    input  dtf_pkg::in_t                     in_data,
    input  dtf_pkg::dtf_cmd_t                cmd,
    output dtf_pkg::dtf_stat_t               stat,
    output dtf_pkg::out_t                    out_data
);

    localparam int unsigned W = dtf_pkg::ValueWidth;
    localparam logic [dtf_pkg::DecWidth-1:0] CntOne = {{(dtf_pkg::DecWidth-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_WHOLE,
        PH_FRAC
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [W-1:0]                    whole_reg, whole_next;
    logic [W-1:0]                    frac_reg, frac_next;
    logic [dtf_pkg::DecWidth-1:0]    cnt_reg, cnt_next;
    logic [dtf_pkg::DecWidth-1:0]    step_reg, step_next;
    logic                            seen_reg, seen_next;
    logic [1:0]                      err_reg, err_next;
    logic [dtf_pkg::DecWidth-1:0]    decimals_reg;
    logic [W-1:0]                    value_reg, value_next;
    logic [1:0]                      status_reg, status_next;

    logic [dtf_pkg::DecWidth-1:0]    dec_eff;
    logic [7:0]                      c;
    logic                            is_digit;
    logic [3:0]                      dval;
    logic [W+3:0]                    whole_mul;
    logic [W+3:0]                    whole_dig;
    logic [W-1:0]                    frac_mul;
    logic [W:0]                      sum;

    assign dec_eff  = (decimals_reg > dtf_pkg::MaxDecimals) ? dtf_pkg::MaxDecimals
                                                             : decimals_reg;
    assign c        = in_data.character;
    assign is_digit = (c >= dtf_pkg::ChZero) && (c <= dtf_pkg::ChNine);
    assign dval     = c[3:0];

    assign whole_mul = ({4'b0, whole_reg} << 3) + ({4'b0, whole_reg} << 1);
    assign whole_dig = whole_mul + {{W{1'b0}}, dval};
    assign frac_mul  = (frac_reg << 3) + (frac_reg << 1);
    assign sum       = {1'b0, whole_reg} + {1'b0, frac_reg};

    assign stat.scale_done = (step_reg == dec_eff);
    assign out_data.value  = value_reg;
    assign out_data.status = status_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        seen_next   = seen_reg;
        err_next    = err_reg;
        value_next  = value_reg;
        status_next = status_reg;

        if (cmd.take && err_reg == dtf_pkg::StOk)
        begin
            if (phase_reg == PH_LEAD && c == dtf_pkg::ChSpace)
            begin
                phase_next = PH_LEAD;
            end
            else if (phase_reg != PH_FRAC)
            begin
                seen_next  = 1'b1;
                phase_next = PH_WHOLE;
                if (is_digit)
                begin
                    if (whole_dig[W+3:W] != 4'd0)
                    begin
                        err_next = dtf_pkg::StOvf;
                    end
                    else
                    begin
                        whole_next = whole_dig[W-1:0];
                    end
                end
                else if (c == dtf_pkg::ChDot)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    err_next = dtf_pkg::StBad;
                end
            end
            else if (cnt_reg < dec_eff)
            begin
                if (is_digit)
                begin
                    frac_next = frac_mul + {{(W-4){1'b0}}, dval};
                    cnt_next  = cnt_reg + CntOne;
                end
                else
                begin
                    err_next = dtf_pkg::StBad;
                end
            end
        end

        // one decade of scaling per cycle; fraction padded up to decimals
        if (cmd.scale_step)
        begin
            step_next  = step_reg + CntOne;
            whole_next = whole_mul[W-1:0];
            if (whole_mul[W+3:W] != 4'd0 && err_reg == dtf_pkg::StOk)
            begin
                err_next = dtf_pkg::StOvf;
            end
            if (cnt_reg < dec_eff)
            begin
                frac_next = frac_mul;
                cnt_next  = cnt_reg + CntOne;
            end
        end

        if (cmd.finish)
        begin
            if (err_reg != dtf_pkg::StOk)
            begin
                status_next = err_reg;
            end
            else if (!seen_reg)
            begin
                status_next = dtf_pkg::StEmpty;
            end
            else if (sum[W])
            begin
                status_next = dtf_pkg::StOvf;
            end
            else
            begin
                status_next = dtf_pkg::StOk;
            end
            value_next = (status_next == dtf_pkg::StOk) ? sum[W-1:0] : {W{1'b0}};
            phase_next = PH_LEAD;
            whole_next = {W{1'b0}};
            frac_next  = {W{1'b0}};
            cnt_next   = '0;
            step_next  = '0;
            seen_next  = 1'b0;
            err_next   = dtf_pkg::StOk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            whole_reg    <= '0;
            frac_reg     <= '0;
            cnt_reg      <= '0;
            step_reg     <= '0;
            seen_reg     <= 1'b0;
            err_reg      <= dtf_pkg::StOk;
            decimals_reg <= dtf_pkg::ResetDecimals;
        end
        else
        begin
            phase_reg <= phase_next;
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
            if (cfg_write_en)
            begin
                decimals_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            status_reg <= dtf_pkg::StOk;
        end
        else
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dtf_pkg::MaxDecimals)
        else $error("fraction count beyond maximum");

endmodule
